// ===== rtl/core/scfp_pkg.sv =====
// Shared constants and types for the screen command frame parser.
// No dependencies; imported by the core and its checker.
package scfp_pkg;

  // Command length in bytes; supported range 3 to 8
  localparam int CMD_BYTES  = 4;
  localparam int CMD_IDX_W  = (CMD_BYTES > 1) ? $clog2(CMD_BYTES) : 1;
  localparam int WORD_BYTES = (CMD_BYTES < 4) ? CMD_BYTES : 4;

  localparam logic [7:0] HDR_BYTE     = 8'h5A;
  localparam logic [7:0] TRL_BYTE     = 8'hA5;
  localparam logic [7:0] CMD_GRP_BYTE = 8'h00;
  localparam logic [7:0] CMD_PIC_BYTE = 8'h03;
  localparam logic [7:0] CMD_DL_BYTE  = 8'h10;

  typedef enum logic [1:0] {
    KIND_PIC   = 2'd0,
    KIND_DL    = 2'd1,
    KIND_OTHER = 2'd2
  } kind_t;

  typedef enum logic [6:0] {
    PH_HUNT0   = 7'b0000001,
    PH_HUNT1   = 7'b0000010,
    PH_CMD     = 7'b0000100,
    PH_DL_LEN  = 7'b0001000,
    PH_DL_DATA = 7'b0010000,
    PH_PIC     = 7'b0100000,
    PH_TRAILER = 7'b1000000
  } phase_t;

  typedef logic [7:0] byte_t;

endpackage

// ===== rtl/core/screen_command_frame_parser_core.sv =====
// Screen command frame parser core: byte-wise frame state machine with a result register.
// Depends on scfp_pkg.
// Each accepted input beat's result is registered and appears in the next cycle.
// Throughput: one beat per cycle; a new input beat is taken whenever the result
// register is empty or is drained in the same cycle.
// Reset: synchronous, active low; clears the phase, counters, command bytes and
// the result valid, and sets the frame kind to "other".
module screen_command_frame_parser_core
  import scfp_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  // input channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_rx_byte,
  // result channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_payload_valid,
  output logic [7:0]  out_payload_byte,
  output logic [15:0] out_payload_index,
  output logic        out_download_start,
  output logic        out_frame_done,
  output logic        out_frame_ok,
  output logic [1:0]  out_command_kind,
  output logic [31:0] out_command_word
);

  // Parser state
  phase_t      phase_r, phase_nxt;
  logic [15:0] byte_count_r, byte_count_nxt;
  logic [15:0] exp_len_r, exp_len_nxt;
  byte_t       cmd_r [CMD_BYTES];
  byte_t       cmd_nxt [CMD_BYTES];
  byte_t       len_high_r, len_high_nxt;
  kind_t       kind_r, kind_nxt;

  // Result register
  logic        out_valid_r;
  logic        pv_r, pv_nxt;
  byte_t       pb_r, pb_nxt;
  logic [15:0] pi_r, pi_nxt;
  logic        ds_r, ds_nxt;
  logic        fd_r, fd_nxt;
  logic        fo_r, fo_nxt;
  logic [31:0] word_r, word_nxt;

  logic        accept;
  logic [15:0] cnt_inc;
  byte_t       b;

  // Stall only while a finished result is held and the sink is stalling;
  // otherwise the result register frees up this cycle.
  assign in_stall = out_valid_r && out_stall;
  assign accept   = in_valid && !in_stall;
  assign b        = in_rx_byte;
  assign cnt_inc  = byte_count_r + 16'd1;

  // Next state and result for the current beat
  always_comb begin
    phase_nxt      = phase_r;
    byte_count_nxt = byte_count_r;
    exp_len_nxt    = exp_len_r;
    len_high_nxt   = len_high_r;
    kind_nxt       = kind_r;
    for (int i = 0; i < CMD_BYTES; i++) begin
      cmd_nxt[i] = cmd_r[i];
    end
    pv_nxt = 1'b0;
    pb_nxt = '0;
    pi_nxt = '0;
    ds_nxt = 1'b0;
    fd_nxt = 1'b0;
    fo_nxt = 1'b0;

    case (phase_r)
      PH_HUNT0: begin
        phase_nxt      = (b == HDR_BYTE) ? PH_HUNT1 : PH_HUNT0;
        byte_count_nxt = '0;
      end
      PH_HUNT1: begin
        phase_nxt      = (b == HDR_BYTE) ? PH_CMD : PH_HUNT0;
        byte_count_nxt = '0;
      end
      PH_CMD: begin
        // Store the byte first; the decode below sees the completed command
        if (byte_count_r < 16'(CMD_BYTES)) begin
          cmd_nxt[byte_count_r[CMD_IDX_W-1:0]] = b;
        end
        byte_count_nxt = cnt_inc;
        if (cnt_inc >= 16'(CMD_BYTES)) begin
          byte_count_nxt = '0;
          if (cmd_nxt[0] == CMD_GRP_BYTE && cmd_nxt[1] == CMD_PIC_BYTE) begin
            phase_nxt   = PH_PIC;
            kind_nxt    = KIND_PIC;
            // cmd[2]*4-1, wrapping so that zero gives 65535
            exp_len_nxt = {6'd0, cmd_nxt[2], 2'b00} - 16'd1;
          end else if (cmd_nxt[0] == CMD_GRP_BYTE && cmd_nxt[1] == CMD_DL_BYTE) begin
            phase_nxt = PH_DL_LEN;
            kind_nxt  = KIND_DL;
            ds_nxt    = 1'b1;
          end else begin
            phase_nxt = PH_TRAILER;
            kind_nxt  = KIND_OTHER;
          end
        end
      end
      PH_DL_LEN: begin
        // Length bytes count as payload bytes 0 and 1
        pv_nxt = 1'b1;
        pb_nxt = b;
        pi_nxt = byte_count_r;
        if (byte_count_r == 16'd0) begin
          len_high_nxt = b;
        end
        byte_count_nxt = cnt_inc;
        if (cnt_inc == 16'd2) begin
          phase_nxt   = PH_DL_DATA;
          exp_len_nxt = {len_high_r, b} + 16'd2;
        end
      end
      PH_DL_DATA, PH_PIC: begin
        pv_nxt         = 1'b1;
        pb_nxt         = b;
        pi_nxt         = byte_count_r;
        byte_count_nxt = cnt_inc;
        if (cnt_inc == exp_len_r) begin
          phase_nxt = PH_TRAILER;
        end
      end
      PH_TRAILER: begin
        fd_nxt    = 1'b1;
        fo_nxt    = (b == TRL_BYTE);
        phase_nxt = PH_HUNT0;
      end
      default: begin
        phase_nxt = PH_HUNT0;
      end
    endcase

    // First WORD_BYTES command bytes, first byte most significant
    word_nxt = '0;
    for (int i = 0; i < WORD_BYTES; i++) begin
      word_nxt = {word_nxt[23:0], cmd_nxt[i]};
    end
  end

  // Control state: advance on every accepted beat
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_HUNT0;
      byte_count_r <= '0;
      exp_len_r    <= '0;
      len_high_r   <= '0;
      kind_r       <= KIND_OTHER;
      for (int i = 0; i < CMD_BYTES; i++) begin
        cmd_r[i] <= '0;
      end
    end else if (accept) begin
      phase_r      <= phase_nxt;
      byte_count_r <= byte_count_nxt;
      exp_len_r    <= exp_len_nxt;
      len_high_r   <= len_high_nxt;
      kind_r       <= kind_nxt;
      for (int i = 0; i < CMD_BYTES; i++) begin
        cmd_r[i] <= cmd_nxt[i];
      end
    end
  end

  // Result valid: set on accept, drop when taken without a new beat
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (accept) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  // Result payload: load on accept, hold otherwise
  always_ff @(posedge clk) begin
    if (accept) begin
      pv_r   <= pv_nxt;
      pb_r   <= pb_nxt;
      pi_r   <= pi_nxt;
      ds_r   <= ds_nxt;
      fd_r   <= fd_nxt;
      fo_r   <= fo_nxt;
      word_r <= word_nxt;
    end
  end

  // The reported kind is the kind register after the beat
  logic [1:0] kind_out_r;
  always_ff @(posedge clk) begin
    if (accept) begin
      kind_out_r <= kind_nxt;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_payload_valid  = pv_r;
  assign out_payload_byte   = pb_r;
  assign out_payload_index  = pi_r;
  assign out_download_start = ds_r;
  assign out_frame_done     = fd_r;
  assign out_frame_ok       = fo_r;
  assign out_command_kind   = kind_out_r;
  assign out_command_word   = word_r;

endmodule

// ===== rtl/core/scfp_checker.sv =====
// Port-level checker for the screen command frame parser core, with its bind.
// Depends on scfp_pkg.
module scfp_checker
  import scfp_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_stall,
  input logic [7:0]  in_rx_byte,
  input logic        out_valid,
  input logic        out_stall,
  input logic        out_payload_valid,
  input logic [7:0]  out_payload_byte,
  input logic [15:0] out_payload_index,
  input logic        out_download_start,
  input logic        out_frame_done,
  input logic        out_frame_ok,
  input logic [1:0]  out_command_kind,
  input logic [31:0] out_command_word
);

  // A held result beat keeps its payload
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_payload_index)
      && $stable(out_payload_byte) && $stable(out_frame_done))
    else $error("result beat changed while stalled");

  // ok is only reported on a trailer beat
  a_ok_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_frame_ok |-> out_frame_done)
    else $error("frame_ok without frame_done");

  // A beat is never more than one of payload, trailer or download start
  a_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_payload_valid && out_frame_done)
      && !(out_payload_valid && out_download_start)
      && !(out_frame_done && out_download_start))
    else $error("conflicting result flags");

  // Download start reports the download kind
  a_dl_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_download_start |-> out_command_kind == KIND_DL)
    else $error("download_start with wrong kind");

  // Non-payload beats carry a zero byte and index
  a_idle_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_payload_valid |-> out_payload_byte == 8'd0
      && out_payload_index == 16'd0)
    else $error("payload fields set on non-payload beat");

endmodule

bind screen_command_frame_parser_core scfp_checker u_scfp_checker (.*);
